// File: src/mmf_pkg.sv
// shared types and constants for the matrix multiply forward core
package mmf_pkg;

  localparam int ACT_W     = 2;
  localparam int IDX_W     = 6;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 36;
  localparam int POS_W     = 3;
  localparam int DIM_W     = 4;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_MM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MV  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd3;

  localparam int IFIFO_DEPTH = 4;
  localparam int IPTR_W      = 2;
  localparam int OFIFO_DEPTH = 8;
  localparam int OPTR_W      = 3;

  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] p;
  } dims_t;

  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] op;
    logic [IDX_W-1:0] index;
  } qhead_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } res_t;

endpackage

// File: src/mmf_front.sv
// front end: accepts requests, drops those with no effect, queues the rest
module mmf_front import mmf_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [IDX_W-1:0]       in_elem_index,
  input  logic signed [IN_W-1:0] in_elem_value,
  input  logic [MODE_W-1:0]      mode,
  output qhead_t                 q_head,
  output logic [ELEM_WIDTH-1:0]  q_value,
  input  logic                   q_pop
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [ACT_W-1:0]      op_mem  [IFIFO_DEPTH];
  logic [IDX_W-1:0]      idx_mem [IFIFO_DEPTH];
  logic [ELEM_WIDTH-1:0] val_mem [IFIFO_DEPTH];

  logic [IPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [IPTR_W:0]   cnt_r, cnt_nxt;
  logic              keep, idx_ok, wr, rd;

  assign idx_ok = ({1'b0, in_elem_index} < (IDX_W + 1)'(DEPTH));

  always_comb begin
    unique case (in_action) inside
      ACT_LOAD_A, ACT_LOAD_B: keep = idx_ok;
      ACT_COMPUTE:            keep = (mode == MODE_MM) || (mode == MODE_MV) ||
                                     (mode == MODE_DOT);
      default:                keep = 1'b0;
    endcase
  end

  assign full = (cnt_r == (IPTR_W + 1)'(IFIFO_DEPTH));
  assign wr   = push && !full && keep;
  assign rd   = q_pop && (cnt_r != '0);

  assign wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
  assign rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt = cnt_r + (IPTR_W + 1)'(wr) - (IPTR_W + 1)'(rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // narrow stores keep the low bits, wide ones sign-extend
  always_ff @(posedge clk) begin
    if (wr) begin
      op_mem[wp_r]  <= in_action;
      idx_mem[wp_r] <= in_elem_index;
      val_mem[wp_r] <= ELEM_WIDTH'(in_elem_value);
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.op    = op_mem[rp_r];
  assign q_head.index = idx_mem[rp_r];
  assign q_value      = val_mem[rp_r];

endmodule

// File: src/mmf_back.sv
// back end: operand stores, multiply-accumulate pipeline and result queue
module mmf_back import mmf_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dims_t                   dims,
  input  qhead_t                  q_head,
  input  logic [ELEM_WIDTH-1:0]   q_value,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [OUT_W-1:0] out_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W = 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

  logic                         state_r, state_nxt;
  logic [POS_W-1:0]             i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                         lastk, lastj, lasti, stall, issue, take;
  logic                         wr_a, wr_b, start;
  logic [LIN_W-1:0]             a_lin, b_lin;
  logic [AW-1:0]                a_addr, b_addr;
  logic signed [ELEM_WIDTH-1:0] a_dat_r, b_dat_r;
  logic signed [2*ELEM_WIDTH-1:0] prod_r;
  logic signed [OUT_W-1:0]      prod_x, acc_r, acc_nxt;
  tag_t                         s1_r, s1_nxt, s2_r;
  logic [OPTR_W+1:0]            pending;

  res_t              ofifo [OFIFO_DEPTH];
  res_t              res;
  logic [OPTR_W-1:0] owp_r, orp_r;
  logic [OPTR_W:0]   ocnt_r;
  logic              opush, opop;

  // front queue is served only between compute runs
  assign take  = (state_r == ST_IDLE) && q_head.valid;
  assign q_pop = take;
  assign wr_a  = take && (q_head.op == ACT_LOAD_A);
  assign wr_b  = take && (q_head.op == ACT_LOAD_B);
  assign start = take && (q_head.op == ACT_COMPUTE);

  assign lastk = ({1'b0, k_r} == dims.n - DIM_W'(1));
  assign lastj = ({1'b0, j_r} == dims.p - DIM_W'(1));
  assign lasti = ({1'b0, i_r} == dims.m - DIM_W'(1));

  // a beat that closes a dot product needs a free slot in the result queue
  assign pending = (OPTR_W + 2)'(ocnt_r) + (OPTR_W + 2)'(s1_r.valid && s1_r.lastk) +
                   (OPTR_W + 2)'(s2_r.valid && s2_r.lastk);
  assign stall   = lastk && (pending >= (OPTR_W + 2)'(OFIFO_DEPTH));
  assign issue   = (state_r == ST_RUN) && !stall;

  assign a_lin  = LIN_W'(i_r) * LIN_W'(dims.n) + LIN_W'(k_r);
  assign b_lin  = LIN_W'(k_r) * LIN_W'(dims.p) + LIN_W'(j_r);
  assign a_addr = a_lin[AW-1:0];
  assign b_addr = b_lin[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (!lastk) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (!lastj) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (!lasti) begin
                i_nxt = i_r + 1'b1;
              end else begin
                i_nxt     = '0;
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    s1_nxt.valid = issue;
    s1_nxt.first = (k_r == '0);
    s1_nxt.lastk = lastk;
    s1_nxt.row   = i_r;
    s1_nxt.col   = j_r;
    s1_nxt.last  = lastk && lastj && lasti;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) a_mem[q_head.index[AW-1:0]] <= q_value;
    if (issue) a_dat_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) b_mem[q_head.index[AW-1:0]] <= q_value;
    if (issue) b_dat_r <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (s1_r.valid) prod_r <= a_dat_r * b_dat_r;
  end

  // product sign-extended, or wrapped when the elements are wide
  assign prod_x  = OUT_W'(prod_r);
  assign acc_nxt = s2_r.first ? prod_x : acc_r + prod_x;

  always_ff @(posedge clk) begin
    if (s2_r.valid) acc_r <= acc_nxt;
  end

  assign opush     = s2_r.valid && s2_r.lastk;
  assign opop      = pop && (ocnt_r != '0);
  assign res.value = acc_nxt;
  assign res.row   = s2_r.row;
  assign res.col   = s2_r.col;
  assign res.last  = s2_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 1'b1;
      if (opop) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + (OPTR_W + 1)'(opush) - (OPTR_W + 1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) ofifo[owp_r] <= res;
  end

  assign empty     = (ocnt_r == '0);
  assign out_value = ofifo[orp_r].value;
  assign out_row   = ofifo[orp_r].row;
  assign out_col   = ofifo[orp_r].col;
  assign out_last  = ofifo[orp_r].last;

endmodule

// File: src/matrix_multiply_forward_core.sv
// top level of the matrix multiply forward core: configuration registers and the two halves
// Load requests write one operand element each and pass through the front queue at one per
// cycle while no compute runs. A compute request runs a single shared multiply-accumulate
// unit that reads one A and one B element per cycle from the two operand stores while the
// result queue has room, so a run issues rows x inner x cols reads (rows x inner in vector
// mode, inner in dot mode). Each read passes the operand read registers and the product
// register before its sum is written to the result queue. Requests behind a compute wait
// in the four-entry front queue until the run has issued its last read. Results leave through
// an eight-entry queue; when it is full the run pauses. Loads to an index beyond the store,
// an unused action code, and a compute in the unused mode are dropped without any result.
module matrix_multiply_forward_core import mmf_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [IDX_W-1:0]        in_elem_index,
  input  logic signed [IN_W-1:0]  in_elem_value,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [OUT_W-1:0] out_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

  logic [MODE_W-1:0]     mode_r;
  logic [DIM_W-1:0]      rows_a_r, inner_dim_r, cols_b_r;
  dims_t                 dims;
  qhead_t                q_head;
  logic [ELEM_WIDTH-1:0] q_value;
  logic                  q_pop;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) r = DIM_W'(1);
    else if (d > MAXD) r = MAXD;
    else r = d;
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MM;
      rows_a_r    <= DIM_W'(1);
      inner_dim_r <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // vector and dot modes collapse to single-column or single-element shapes
  always_comb begin
    dims.m = (mode_r == MODE_DOT) ? DIM_W'(1) : clamp_dim(rows_a_r);
    dims.n = clamp_dim(inner_dim_r);
    dims.p = (mode_r == MODE_MM) ? clamp_dim(cols_b_r) : DIM_W'(1);
  end

  mmf_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .mode          (mode_r),
    .q_head        (q_head),
    .q_value       (q_value),
    .q_pop         (q_pop)
  );

  mmf_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .q_head    (q_head),
    .q_value   (q_value),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_value (out_value),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last)
  );

endmodule

// File: src/mmf_checker.sv
// port-level checks for the matrix multiply forward core, bound to the top level
module mmf_checker import mmf_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic signed [OUT_W-1:0] out_value,
  input logic [POS_W-1:0]        out_row,
  input logic [POS_W-1:0]        out_col,
  input logic                    out_last
);

  // both queues come out of reset empty
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  // a waiting result holds until it is taken
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_value) && $stable(out_row) &&
                       $stable(out_col) && $stable(out_last))
    else $error("result changed while waiting");

  // results only go away by being popped
  a_drain_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty) |-> $past(pop))
    else $error("result queue emptied without a pop");

endmodule

bind matrix_multiply_forward_core mmf_checker u_mmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_value (out_value),
  .out_row   (out_row),
  .out_col   (out_col),
  .out_last  (out_last)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the matrix multiply forward core with its product scoreboard
module tb_top;
  import mmf_pkg::*;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 160;
  localparam int STORE_DEPTH   = 64;
  localparam int DIM_MAX       = 8;

  localparam logic [ACT_W-1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  class product_scoreboard;
    logic [MODE_W-1:0]      mode;
    logic [DIM_W-1:0]       rows_a;
    logic [DIM_W-1:0]       inner_dim;
    logic [DIM_W-1:0]       cols_b;
    logic signed [IN_W-1:0] a_elems[STORE_DEPTH];
    logic signed [IN_W-1:0] b_elems[STORE_DEPTH];
    bit                     a_written[STORE_DEPTH];
    bit                     b_written[STORE_DEPTH];
    res_t                   expected_elems[$];
    int                     mismatches;
    int                     results_seen;
    int                     computes_seen;

    function new();
      mode      = MODE_MM;
      rows_a    = 1;
      inner_dim = 1;
      cols_b    = 1;
    endfunction

    function int eff_dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return int'(d);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_MODE:      mode = data[MODE_W-1:0];
        REG_ROWS_A:    rows_a = data;
        REG_INNER_DIM: inner_dim = data;
        REG_COLS_B:    cols_b = data;
        default: ;
      endcase
    endfunction

    // how many leading entries of each store a compute reads
    function void operand_spans(output int a_cnt, output int b_cnt);
      int m, n, p;
      m = eff_dim(rows_a);
      n = eff_dim(inner_dim);
      p = eff_dim(cols_b);
      case (mode)
        MODE_MM: begin
          a_cnt = m * n;
          b_cnt = n * p;
        end
        MODE_MV: begin
          a_cnt = m * n;
          b_cnt = n;
        end
        MODE_DOT: begin
          a_cnt = n;
          b_cnt = n;
        end
        default: begin
          a_cnt = 0;
          b_cnt = 0;
        end
      endcase
    endfunction

    function logic signed [OUT_W-1:0] dot_sum(int a0, int astep, int b0, int bstep, int n);
      longint acc;
      acc = 0;
      for (int k = 0; k < n; k++)
        acc += longint'(a_elems[a0 + k * astep]) * longint'(b_elems[b0 + k * bstep]);
      return acc[OUT_W-1:0];
    endfunction

    function void add_elem(logic signed [OUT_W-1:0] v, int r, int c, bit lst);
      res_t e;
      e.value = v;
      e.row   = POS_W'(r);
      e.col   = POS_W'(c);
      e.last  = lst;
      expected_elems.push_back(e);
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                               logic signed [IN_W-1:0] val);
      int m, n, p;
      m = eff_dim(rows_a);
      n = eff_dim(inner_dim);
      p = eff_dim(cols_b);
      case (act)
        ACT_LOAD_A: begin
          a_elems[idx]   = val;
          a_written[idx] = 1'b1;
        end
        ACT_LOAD_B: begin
          b_elems[idx]   = val;
          b_written[idx] = 1'b1;
        end
        ACT_COMPUTE: begin
          computes_seen++;
          if (mode == MODE_MM) begin
            for (int i = 0; i < m; i++)
              for (int j = 0; j < p; j++)
                add_elem(dot_sum(i * n, 1, j, p, n), i, j, (i == m - 1) && (j == p - 1));
          end else if (mode == MODE_MV) begin
            for (int i = 0; i < m; i++)
              add_elem(dot_sum(i * n, 1, 0, 1, n), i, 0, i == m - 1);
          end else if (mode == MODE_DOT) begin
            add_elem(dot_sum(0, 1, 0, 1, n), 0, 0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [OUT_W-1:0] v, logic [POS_W-1:0] r,
                               logic [POS_W-1:0] c, logic lst);
      res_t want;
      results_seen++;
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d row %0d col %0d last %0d", v, r, c, lst);
        return;
      end
      want = expected_elems.pop_front();
      if (want.value !== v || want.row !== r || want.col !== c || want.last !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want value %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                   want.value, want.row, want.col, want.last, v, r, c, lst);
      end
    endfunction
  endclass

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    push          = 1'b0;
  logic                    full;
  logic [ACT_W-1:0]        in_action     = ACT_LOAD_A;
  logic [IDX_W-1:0]        in_elem_index = '0;
  logic signed [IN_W-1:0]  in_elem_value = '0;
  logic                    empty;
  logic                    pop           = 1'b0;
  logic signed [OUT_W-1:0] out_value;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    out_last;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = REG_MODE;
  logic [DIM_W-1:0]        cfg_data      = '0;

  product_scoreboard sb = new();
  bit tx_eager;
  bit rx_eager;
  int items_sent;
  int reg_writes;
  int phases;
  int cycles;

  matrix_multiply_forward_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .empty         (empty),
    .pop           (pop),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] random_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return IN_W'($urandom_range(0, 3));
      3: return ~IN_W'($urandom_range(0, 255));
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return DIM_W'(DIM_MAX);
      2: return DIM_W'($urandom_range(DIM_MAX + 1, 15));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return MODE_MM;
      4, 5, 6:    return MODE_MV;
      7, 8:       return MODE_DOT;
      default:    return MODE_UNUSED;
    endcase
  endfunction

  // all drive tasks are entered at a rising edge
  task automatic send_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                           logic [IN_W-1:0] val);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_action     <= act;
    in_elem_index <= idx;
    in_elem_value <= val;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_request(act, idx, val);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic program_regs(logic [DIM_W-1:0] mode_v, rows_v, inner_v, cols_v);
    logic [CFG_IDX_W-1:0] regs[4];
    logic [DIM_W-1:0]     vals[4];
    regs = '{REG_MODE, REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
    vals = '{mode_v, rows_v, inner_v, cols_v};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_reg(regs[r], vals[r]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    phases++;
  endtask

  // loads may still sit in the front queue after the last result, so let them drain too
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // fill every entry the next compute reads, rewriting some that already hold data
  task automatic load_operands();
    int a_cnt, b_cnt, ia, ib;
    sb.operand_spans(a_cnt, b_cnt);
    ia = 0;
    ib = 0;
    while (ia < a_cnt || ib < b_cnt) begin
      if (ib >= b_cnt || (ia < a_cnt && $urandom_range(0, 1) == 1)) begin
        if (!sb.a_written[ia] || $urandom_range(0, 2) != 0)
          send_item(ACT_LOAD_A, IDX_W'(ia), random_elem());
        ia++;
      end else begin
        if (!sb.b_written[ib] || $urandom_range(0, 2) != 0)
          send_item(ACT_LOAD_B, IDX_W'(ib), random_elem());
        ib++;
      end
    end
  endtask

  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      sb.check_result(out_value, out_row, out_col, out_last);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset dimensions, most negative operands squared
    send_item(ACT_LOAD_A, 0, 16'h8000);
    send_item(ACT_LOAD_B, 0, 16'h8000);
    send_item(ACT_COMPUTE, 0, 0);
    send_item(ACT_LOAD_A, 63, 16'h7fff);
    send_item(ACT_LOAD_B, 63, 16'hffff);
    send_item(ACT_UNUSED, 63, 16'hffff);
    send_item(ACT_COMPUTE, 63, 16'h7fff);
    wait_drained();

    // zero rows act as one, cols ignored outside matrix mode
    program_regs(DIM_W'(MODE_MV), 0, 2, 15);
    send_item(ACT_LOAD_A, 1, 16'h8000);
    send_item(ACT_LOAD_B, 1, 16'h7fff);
    send_item(ACT_COMPUTE, 0, 0);
    wait_drained();

    program_regs(DIM_W'(MODE_DOT), 9, 0, 0);
    send_item(ACT_COMPUTE, 0, 0);
    wait_drained();

    program_regs(DIM_W'(MODE_MM), 2, 1, 2);
    send_item(ACT_COMPUTE, 0, 0);
    wait_drained();

    // unused mode swallows the compute
    program_regs(DIM_W'(MODE_UNUSED), 8, 8, 8);
    send_item(ACT_COMPUTE, 0, 0);
    send_item(ACT_LOAD_A, 2, 16'h0100);
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      program_regs({2'($urandom_range(0, 3)), pick_mode()}, pick_dim(), pick_dim(),
                   pick_dim());
      repeat ($urandom_range(1, 3)) begin
        load_operands();
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 2) == 0)
            send_item(ACT_UNUSED, IDX_W'($urandom), IN_W'($urandom));
          else
            send_item($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A, IDX_W'($urandom),
                      random_elem());
        end
        // now and then a load sequence is left without its compute
        if ($urandom_range(0, 9) != 0)
          send_item(ACT_COMPUTE, IDX_W'($urandom), IN_W'($urandom));
      end
      wait_drained();
    end

    $display("%0d config phases with %0d register writes, %0d computes issued",
             phases, reg_writes, sb.computes_seen);
    $display("%0d product elements checked, %0d mismatches", sb.results_seen,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: matrix_multiply_forward_core.f
src/mmf_pkg.sv
src/mmf_front.sv
src/mmf_back.sv
src/matrix_multiply_forward_core.sv
src/mmf_checker.sv
verif/tb_top.sv
